// ===== hw/rtl/closest_point_on_segment_defines.svh =====
// Assertion macros shared by the closest point on segment checker.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef CLOSEST_POINT_ON_SEGMENT_DEFINES_SVH
`define CLOSEST_POINT_ON_SEGMENT_DEFINES_SVH

// Property checked at every clock edge while reset is released.
`define CPOS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("cpos: property violated");

// Property checked at every clock edge, reset included.
`define CPOS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cpos: property violated");

`endif

// ===== hw/rtl/cpos_pkg.sv =====
// Shared widths, clamp codes and the divider item type for the closest point block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cpos_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = COORD_W;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DOT_W   = PROD_W + 1;
    localparam int QUO_W   = 32;
    localparam int SCL_W   = MAG_W + QUO_W;
    localparam int PIPE_LATENCY = QUO_W + 5;

    localparam logic [SCL_W:0] ROUND_HALF = (SCL_W + 1)'(1) << (QUO_W - 1);

    typedef enum logic [1:0] {
        CLAMP_NONE  = 2'd0,
        CLAMP_START = 2'd1,
        CLAMP_END   = 2'd2
    } t_clamp;

    typedef struct packed {
        logic                      valid;
        t_clamp                    code;
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        logic signed [DIFF_W-1:0]  dir_x;
        logic signed [DIFF_W-1:0]  dir_y;
        logic [DOT_W-1:0]          rem;
        logic [DOT_W-1:0]          dvs;
        logic [QUO_W-1:0]          quo;
    } t_div_item;

endpackage

`default_nettype wire

// ===== hw/rtl/closest_point_on_segment.sv =====
// Closest point on a 2-D segment, signed Q16.16, one item per clock cycle.
// An accepted item passes through these stages to the strobe:
// three front stages, one divider cell per quotient bit (32 cells), then scale and round.
// Throughput is one item every cycle; busy is high only while reset is held.
// Synchronous reset empties the pipeline; the receiver cannot stall results.
// Depends on cpos_pkg, cpos_front, cpos_div_cell and cpos_back.
`default_nettype none

module closest_point_on_segment (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] i_start_x,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] i_start_y,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] i_end_x,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] i_end_y,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] i_point_x,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] i_point_y,
    output logic                                     o_strobe,
    output logic signed [cpos_pkg::COORD_W-1:0]      o_nearest_x,
    output logic signed [cpos_pkg::COORD_W-1:0]      o_nearest_y,
    output logic [1:0]                               o_clamp_code
);
    import cpos_pkg::*;

    logic      w_accept;
    t_div_item w_chain [QUO_W+1];

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    cpos_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .o_item    (w_chain[0])
    );

    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        cpos_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (w_chain[g]),
            .o_item  (w_chain[g+1])
        );
    end

    cpos_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_chain[QUO_W]),
        .o_strobe     (o_strobe),
        .o_nearest_x  (o_nearest_x),
        .o_nearest_y  (o_nearest_y),
        .o_clamp_code (o_clamp_code)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/cpos_front.sv =====
// Front pipeline: differences, four products, dot products and clamp decision.
// Depends on cpos_pkg; feeds the first divider cell.
`default_nettype none

module cpos_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_accept,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] i_start_x,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] i_start_y,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] i_end_x,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] i_end_y,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] i_point_x,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] i_point_y,
    output cpos_pkg::t_div_item                      o_item
);
    import cpos_pkg::*;

    logic                      r_s1_valid;
    logic signed [COORD_W-1:0] r_s1_sx, r_s1_sy, r_s1_ex, r_s1_ey;
    logic signed [DIFF_W-1:0]  r_s1_dx, r_s1_dy, r_s1_vx, r_s1_vy;

    logic                      r_s2_valid;
    logic signed [COORD_W-1:0] r_s2_sx, r_s2_sy, r_s2_ex, r_s2_ey;
    logic signed [DIFF_W-1:0]  r_s2_vx, r_s2_vy;
    logic signed [PROD_W-1:0]  r_s2_pdx, r_s2_pdy, r_s2_pvx, r_s2_pvy;
    logic signed [PROD_W-1:0]  n_s2_pdx, n_s2_pdy, n_s2_pvx, n_s2_pvy;

    logic signed [DOT_W-1:0]   w_dot1, w_dot2;
    t_div_item                 r_item, n_item;

    always_ff @(posedge i_clk) begin
        r_s1_valid <= i_accept;
        r_s1_sx    <= i_start_x;
        r_s1_sy    <= i_start_y;
        r_s1_ex    <= i_end_x;
        r_s1_ey    <= i_end_y;
        r_s1_dx    <= {i_point_x[COORD_W-1], i_point_x} - {i_start_x[COORD_W-1], i_start_x};
        r_s1_dy    <= {i_point_y[COORD_W-1], i_point_y} - {i_start_y[COORD_W-1], i_start_y};
        r_s1_vx    <= {i_end_x[COORD_W-1], i_end_x} - {i_start_x[COORD_W-1], i_start_x};
        r_s1_vy    <= {i_end_y[COORD_W-1], i_end_y} - {i_start_y[COORD_W-1], i_start_y};
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_comb begin
        n_s2_pdx = r_s1_dx * r_s1_vx;
        n_s2_pdy = r_s1_dy * r_s1_vy;
        n_s2_pvx = r_s1_vx * r_s1_vx;
        n_s2_pvy = r_s1_vy * r_s1_vy;
    end

    always_ff @(posedge i_clk) begin
        r_s2_valid <= r_s1_valid;
        r_s2_sx    <= r_s1_sx;
        r_s2_sy    <= r_s1_sy;
        r_s2_ex    <= r_s1_ex;
        r_s2_ey    <= r_s1_ey;
        r_s2_vx    <= r_s1_vx;
        r_s2_vy    <= r_s1_vy;
        r_s2_pdx   <= n_s2_pdx;
        r_s2_pdy   <= n_s2_pdy;
        r_s2_pvx   <= n_s2_pvx;
        r_s2_pvy   <= n_s2_pvy;
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_comb begin
        w_dot1 = r_s2_pdx + r_s2_pdy;
        w_dot2 = r_s2_pvx + r_s2_pvy;
        n_item.valid  = r_s2_valid;
        n_item.dir_x  = r_s2_vx;
        n_item.dir_y  = r_s2_vy;
        n_item.rem    = w_dot1;
        n_item.dvs    = w_dot2;
        n_item.quo    = '0;
        if (w_dot1[DOT_W-1] || (w_dot1 == '0)) begin
            n_item.code   = CLAMP_START;
            n_item.base_x = r_s2_sx;
            n_item.base_y = r_s2_sy;
        end else if (w_dot2 <= w_dot1) begin
            n_item.code   = CLAMP_END;
            n_item.base_x = r_s2_ex;
            n_item.base_y = r_s2_ey;
        end else begin
            n_item.code   = CLAMP_NONE;
            n_item.base_x = r_s2_sx;
            n_item.base_y = r_s2_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

// ===== hw/rtl/cpos_div_cell.sv =====
// One cell of the restoring divider chain: produces one quotient bit per item.
// Depends on cpos_pkg; instanced once per fraction bit by the top level.
`default_nettype none

module cpos_div_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire cpos_pkg::t_div_item  i_item,
    output cpos_pkg::t_div_item       o_item
);
    import cpos_pkg::*;

    logic [DOT_W-1:0] w_shifted;
    logic [DOT_W:0]   w_trial;
    logic             w_take;
    t_div_item        r_item, n_item;

    always_comb begin
        w_shifted = {i_item.rem[DOT_W-2:0], 1'b0};
        w_trial   = {1'b0, w_shifted} - {1'b0, i_item.dvs};
        w_take    = ~w_trial[DOT_W];
        n_item     = i_item;
        n_item.rem = w_take ? w_trial[DOT_W-1:0] : w_shifted;
        n_item.quo = {i_item.quo[QUO_W-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

// ===== hw/rtl/cpos_back.sv =====
// Back pipeline: scales the direction by the quotient, rounds and adds the base; clamped items pass the base through.
// Depends on cpos_pkg; takes the item leaving the last divider cell.
`default_nettype none

module cpos_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire cpos_pkg::t_div_item                 i_item,
    output logic                                     o_strobe,
    output logic signed [cpos_pkg::COORD_W-1:0]      o_nearest_x,
    output logic signed [cpos_pkg::COORD_W-1:0]      o_nearest_y,
    output logic [1:0]                               o_clamp_code
);
    import cpos_pkg::*;

    logic [DIFF_W-1:0]         w_abs_x, w_abs_y;
    logic                      r_m_valid;
    t_clamp                    r_m_code;
    logic signed [COORD_W-1:0] r_m_base_x, r_m_base_y;
    logic                      r_m_neg_x, r_m_neg_y;
    logic [SCL_W-1:0]          r_m_prod_x, r_m_prod_y;

    logic [SCL_W:0]            w_sgn_x, w_sgn_y, w_rnd_x, w_rnd_y;
    logic signed [COORD_W-1:0] n_nearest_x, n_nearest_y;
    logic                      r_strobe;
    t_clamp                    r_code;
    logic signed [COORD_W-1:0] r_nearest_x, r_nearest_y;

    always_comb begin
        w_abs_x = i_item.dir_x[DIFF_W-1] ? DIFF_W'(-i_item.dir_x) : i_item.dir_x;
        w_abs_y = i_item.dir_y[DIFF_W-1] ? DIFF_W'(-i_item.dir_y) : i_item.dir_y;
    end

    always_ff @(posedge i_clk) begin
        r_m_valid  <= i_item.valid;
        r_m_code   <= i_item.code;
        r_m_base_x <= i_item.base_x;
        r_m_base_y <= i_item.base_y;
        r_m_neg_x  <= i_item.dir_x[DIFF_W-1];
        r_m_neg_y  <= i_item.dir_y[DIFF_W-1];
        r_m_prod_x <= w_abs_x[MAG_W-1:0] * i_item.quo;
        r_m_prod_y <= w_abs_y[MAG_W-1:0] * i_item.quo;
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end
    end

    always_comb begin
        w_sgn_x = r_m_neg_x ? -{1'b0, r_m_prod_x} : {1'b0, r_m_prod_x};
        w_sgn_y = r_m_neg_y ? -{1'b0, r_m_prod_y} : {1'b0, r_m_prod_y};
        w_rnd_x = w_sgn_x + ROUND_HALF;
        w_rnd_y = w_sgn_y + ROUND_HALF;
        if (r_m_code == CLAMP_NONE) begin
            n_nearest_x = r_m_base_x + w_rnd_x[QUO_W +: COORD_W];
            n_nearest_y = r_m_base_y + w_rnd_y[QUO_W +: COORD_W];
        end else begin
            n_nearest_x = r_m_base_x;
            n_nearest_y = r_m_base_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_strobe    <= r_m_valid;
        r_code      <= r_m_code;
        r_nearest_x <= n_nearest_x;
        r_nearest_y <= n_nearest_y;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_clamp_code = r_code;
    assign o_nearest_x  = r_nearest_x;
    assign o_nearest_y  = r_nearest_y;

endmodule

`default_nettype wire

// ===== hw/rtl/cpos_checker.sv =====
// Port-level checks of the closest point block, bound to its top level.
// Depends on cpos_pkg and closest_point_on_segment_defines.svh.
`default_nettype none
`include "closest_point_on_segment_defines.svh"

module cpos_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic [1:0] o_clamp_code
);
    import cpos_pkg::*;

    `CPOS_ASSERT_ALWAYS(a_reset_flushes, i_clk, !i_rst_n |=> !o_strobe)
    `CPOS_ASSERT(a_item_emerges, i_clk, i_rst_n, (start && !busy) |-> ##PIPE_LATENCY o_strobe)
    `CPOS_ASSERT(a_no_orphan, i_clk, i_rst_n, o_strobe |-> $past(start && !busy, PIPE_LATENCY))
    `CPOS_ASSERT(a_code_legal, i_clk, i_rst_n, o_strobe |-> (o_clamp_code <= CLAMP_END))

endmodule

bind closest_point_on_segment cpos_checker u_cpos_checker (.*);

`default_nettype wire
